FILE: rtl/pba_pkg.sv
// Shared constants, codes and controller/datapath interface types of the page allocator.
`default_nettype none

package pba_pkg;

    localparam int BITMAP_WORDS_DEF = 64;
    localparam int PAGE_SHIFT_DEF   = 12;
    localparam int WORD_BITS_DEF    = 64;

    localparam int ADDR_W    = 48;
    localparam int COUNT_W   = 13;
    localparam int REG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [REG_IDX_W-1:0] REG_MEMORY_BASE   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_MANAGED_PAGES = 1'b1;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_MARK  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_PAGE  = 2'd1;
    localparam logic [1:0] STAT_MISALIGN = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP1,
        S_SETUP2,
        S_DISPATCH,
        S_DIV1,
        S_DIV2,
        S_WALK_RD,
        S_WALK_WR,
        S_SCAN,
        S_ADDR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic       clear_word;
        logic       capture;
        logic       div_mp;
        logic       setup;
        logic       range_free;
        logic       range_mark;
        logic       div_start;
        logic       div_fix;
        logic       scan_start;
        logic       scan_next;
        logic       scan_take;
        logic       make_addr;
        logic       walk_write;
        logic       set_status;
        logic [1:0] status_code;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] action;
        logic       misaligned;
        logic       below_base;
        logic       free_oor;
        logic       mark_empty;
        logic       no_words;
        logic       word_full;
        logic       scan_last;
        logic       walk_last;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/pba_ctrl.sv
// Sequencing state machine of the page allocator.
`default_nettype none

module pba_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire pba_pkg::sts_t sts,
    output pba_pkg::cmd_t      cmd
);
    import pba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SETUP1;
                end
            end
            S_SETUP1:   state_next = S_SETUP2;
            S_SETUP2:   state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (sts.action)
                    ACT_ALLOC:
                    begin
                        state_next = sts.no_words ? S_FINISH : S_SCAN;
                    end
                    ACT_FREE:
                    begin
                        if (sts.misaligned || sts.below_base || sts.free_oor)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_DIV1;
                        end
                    end
                    ACT_MARK:
                    begin
                        if (sts.below_base || sts.mark_empty)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_DIV1;
                        end
                    end
                    default:    state_next = S_FINISH;
                endcase
            end
            S_DIV1:     state_next = S_DIV2;
            S_DIV2:     state_next = S_WALK_RD;
            S_WALK_RD:  state_next = S_WALK_WR;
            S_WALK_WR:
            begin
                state_next = sts.walk_last ? S_FINISH : S_WALK_RD;
            end
            S_SCAN:
            begin
                if (!sts.word_full)
                begin
                    state_next = S_ADDR;
                end
                else if (sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_ADDR:     state_next = S_FINISH;
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:    cmd.clear_word = 1'b1;
            S_IDLE:     cmd.capture    = in_valid;
            S_SETUP1:   cmd.div_mp     = 1'b1;
            S_SETUP2:   cmd.setup      = 1'b1;
            S_DISPATCH:
            begin
                case (sts.action)
                    ACT_ALLOC:
                    begin
                        if (sts.no_words)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_NO_PAGE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                        end
                    end
                    ACT_FREE:
                    begin
                        if (sts.misaligned)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_MISALIGN;
                        end
                        else if (sts.below_base || sts.free_oor)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_RANGE;
                        end
                        else
                        begin
                            cmd.range_free = 1'b1;
                        end
                    end
                    ACT_MARK:
                    begin
                        if (sts.below_base)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_RANGE;
                        end
                        else if (!sts.mark_empty)
                        begin
                            cmd.range_mark = 1'b1;
                        end
                    end
                    default:    cmd.set_status = 1'b0;
                endcase
            end
            S_DIV1:     cmd.div_start  = 1'b1;
            S_DIV2:     cmd.div_fix    = 1'b1;
            S_WALK_WR:  cmd.walk_write = 1'b1;
            S_SCAN:
            begin
                if (!sts.word_full)
                begin
                    cmd.scan_take = 1'b1;
                end
                else if (sts.scan_last)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STAT_NO_PAGE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_ADDR:     cmd.make_addr = 1'b1;
            S_FINISH:   cmd.load_out  = sts.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/pba_datapath.sv
// Bitmap memory, address arithmetic, free count and result register of the page allocator.
`default_nettype none

module pba_datapath #(
    parameter int BITMAP_WORDS = pba_pkg::BITMAP_WORDS_DEF,
    parameter int PAGE_SHIFT   = pba_pkg::PAGE_SHIFT_DEF,
    parameter int WORD_BITS    = pba_pkg::WORD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pba_pkg::cmd_t                   cmd,
    output pba_pkg::sts_t                        sts,
    input  wire logic                            cfg_write,
    input  wire logic [pba_pkg::REG_IDX_W-1:0]   cfg_index,
    input  wire logic [pba_pkg::ADDR_W-1:0]      cfg_data,
    input  wire logic [1:0]                      action,
    input  wire logic [pba_pkg::ADDR_W-1:0]      address,
    input  wire logic [pba_pkg::ADDR_W-1:0]      length,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [pba_pkg::ADDR_W-1:0]           page_address,
    output logic [1:0]                           status,
    output logic [pba_pkg::COUNT_W-1:0]          free_count
);
    import pba_pkg::*;

    localparam int AW     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int WIU_W  = $clog2(BITMAP_WORDS + 1);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int AVL_W  = $clog2(WORD_BITS + 1);
    localparam int LIM_W  = $clog2(BITMAP_WORDS * WORD_BITS + 1);
    localparam int PG_W   = ADDR_W - PAGE_SHIFT;
    localparam int END_W  = PG_W + 1;
    localparam int CMP_W  = (END_W > LIM_W) ? END_W : LIM_W;
    localparam int DIFF_W = ADDR_W + 1;

    // Division by the word width is a multiplication by a rounded-up reciprocal.
    // The shift is wide enough that the quotient is exact for every operand.
    localparam int DIV_N  = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;
    localparam int DIV_SH = DIV_N + 7;
    localparam int R_W    = DIV_SH - 2;
    localparam int PROD_W = DIV_N + R_W;
    localparam logic [R_W-1:0] DIV_R =
        R_W'(((64'd1 << DIV_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

    logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];

    logic [ADDR_W-1:0]    base_reg;
    logic [COUNT_W-1:0]   pages_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [AW-1:0]        clr_reg;
    logic                 out_valid_reg;

    logic [1:0]           action_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    len_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ADDR_W-1:0]    off_reg;
    logic                 below_reg;
    logic [WIU_W-1:0]     wiu_reg;
    logic [LIM_W-1:0]     limit_reg;
    logic [PG_W-1:0]      start_reg;
    logic [END_W-1:0]     end_reg;
    logic [LIM_W-1:0]     rng_reg;
    logic [LIM_W-1:0]     n_reg;
    logic                 clr_mode_reg;
    logic [WIU_W-1:0]     w_reg;
    logic [BIT_W-1:0]     lo_reg;
    logic [LIM_W-1:0]     idx_reg;
    logic [WORD_BITS-1:0] rd_reg;
    logic [ADDR_W-1:0]    page_reg;
    logic [1:0]           stat_reg;
    logic [ADDR_W-1:0]    out_page_reg;
    logic [1:0]           out_stat_reg;
    logic [COUNT_W-1:0]   out_cnt_reg;

    logic [DIV_N-1:0]     div_x;
    logic [DIV_N-1:0]     quot;
    logic [WIU_W-1:0]     wiu_calc;
    logic [LIM_W-1:0]     limit_calc;
    logic [PG_W-1:0]      start_calc;
    logic [END_W-1:0]     end_calc;
    logic [DIFF_W-1:0]    diff;
    logic [CMP_W-1:0]     start_cmp;
    logic [CMP_W-1:0]     end_cmp;
    logic [CMP_W-1:0]     lim_cmp;
    logic [CMP_W-1:0]     endc_cmp;
    logic [LIM_W-1:0]     lo_calc;
    logic [WIU_W-1:0]     w_inc;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] onehot;
    logic [BIT_W-1:0]     free_bit;
    logic [AVL_W-1:0]     avail;
    logic [AVL_W-1:0]     take;
    logic [AVL_W-1:0]     hi;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wr_word;
    logic                 walk_last;
    logic                 out_free;

    assign div_x      = cmd.div_mp ? DIV_N'(pages_reg) : DIV_N'(rng_reg);
    assign quot       = DIV_N'(prod_reg >> DIV_SH);
    assign wiu_calc   = (quot >= DIV_N'(BITMAP_WORDS)) ? WIU_W'(BITMAP_WORDS) : WIU_W'(quot);
    assign limit_calc = LIM_W'(wiu_calc) * LIM_W'(WORD_BITS);
    assign start_calc = PG_W'(off_reg >> PAGE_SHIFT);
    assign end_calc   = END_W'(start_calc) + END_W'(len_reg >> PAGE_SHIFT);
    assign diff       = DIFF_W'(addr_reg) - DIFF_W'(base_reg);

    assign start_cmp  = CMP_W'(start_reg);
    assign end_cmp    = CMP_W'(end_reg);
    assign lim_cmp    = CMP_W'(limit_reg);
    assign endc_cmp   = (end_cmp < lim_cmp) ? end_cmp : lim_cmp;
    assign lo_calc    = rng_reg - LIM_W'(quot) * LIM_W'(WORD_BITS);

    assign w_inc      = w_reg + WIU_W'(1);

    always_comb
    begin
        if (cmd.scan_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan_next)
        begin
            rd_addr = w_inc[AW-1:0];
        end
        else
        begin
            rd_addr = w_reg[AW-1:0];
        end
    end

    // Lowest clear bit as a one-hot vector, then encoded.
    assign onehot = ~rd_reg & (rd_reg + WORD_BITS'(1));

    always_comb
    begin
        free_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (onehot[b])
            begin
                free_bit = free_bit | BIT_W'(b);
            end
        end
    end

    assign avail     = AVL_W'(WORD_BITS) - AVL_W'(lo_reg);
    assign walk_last = (n_reg <= LIM_W'(avail));
    assign take      = walk_last ? AVL_W'(n_reg) : avail;
    assign hi        = AVL_W'(lo_reg) + take;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            mask[b] = (AVL_W'(b) >= AVL_W'(lo_reg)) && (AVL_W'(b) < hi);
        end
    end

    assign wr_word  = clr_mode_reg ? (rd_reg & ~mask) : (rd_reg | mask);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts            = '0;
        sts.clear_last = (clr_reg == AW'(BITMAP_WORDS - 1));
        sts.action     = action_reg;
        sts.misaligned = |addr_reg[PAGE_SHIFT-1:0];
        sts.below_base = below_reg;
        sts.free_oor   = (start_cmp >= lim_cmp);
        sts.mark_empty = (start_cmp >= endc_cmp);
        sts.no_words   = (wiu_reg == '0);
        sts.word_full  = &rd_reg;
        sts.scan_last  = (w_inc == wiu_reg);
        sts.walk_last  = walk_last;
        sts.out_free   = out_free;
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= bitmap_mem[rd_addr];
        if (cmd.clear_word)
        begin
            bitmap_mem[clr_reg] <= '0;
        end
        else if (cmd.scan_take)
        begin
            bitmap_mem[w_reg[AW-1:0]] <= rd_reg | onehot;
        end
        else if (cmd.walk_write)
        begin
            bitmap_mem[w_reg[AW-1:0]] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            pages_reg     <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_word)
            begin
                clr_reg <= clr_reg + AW'(1);
            end

            if (cfg_write)
            begin
                if (cfg_index == REG_MEMORY_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else
                begin
                    pages_reg <= cfg_data[COUNT_W-1:0];
                    cnt_reg   <= cfg_data[COUNT_W-1:0];
                end
            end
            else if (cmd.scan_take && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - COUNT_W'(1);
            end
            else if (cmd.walk_write && walk_last && clr_mode_reg && (cnt_reg != COUNT_MAX))
            begin
                cnt_reg <= cnt_reg + COUNT_W'(1);
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            addr_reg   <= address;
            len_reg    <= length;
            page_reg   <= '0;
            stat_reg   <= STAT_OK;
        end

        if (cmd.div_mp || cmd.div_start)
        begin
            prod_reg <= PROD_W'(div_x) * PROD_W'(DIV_R);
        end

        if (cmd.div_mp)
        begin
            off_reg   <= diff[ADDR_W-1:0];
            below_reg <= diff[ADDR_W];
        end

        if (cmd.setup)
        begin
            wiu_reg   <= wiu_calc;
            limit_reg <= limit_calc;
            start_reg <= start_calc;
            end_reg   <= end_calc;
        end

        if (cmd.range_free)
        begin
            rng_reg      <= LIM_W'(start_reg);
            n_reg        <= LIM_W'(1);
            clr_mode_reg <= 1'b1;
        end
        else if (cmd.range_mark)
        begin
            rng_reg      <= LIM_W'(start_reg);
            n_reg        <= LIM_W'(endc_cmp - start_cmp);
            clr_mode_reg <= 1'b0;
        end
        else if (cmd.walk_write)
        begin
            n_reg <= n_reg - LIM_W'(take);
        end

        if (cmd.div_fix)
        begin
            w_reg  <= WIU_W'(quot);
            lo_reg <= BIT_W'(lo_calc);
        end
        else if (cmd.scan_start)
        begin
            w_reg <= '0;
        end
        else if (cmd.scan_next || cmd.walk_write)
        begin
            w_reg <= w_inc;
        end

        if (cmd.walk_write)
        begin
            lo_reg <= '0;
        end

        if (cmd.scan_take)
        begin
            idx_reg <= LIM_W'(w_reg) * LIM_W'(WORD_BITS) + LIM_W'(free_bit);
        end

        if (cmd.make_addr)
        begin
            page_reg <= base_reg + (ADDR_W'(idx_reg) << PAGE_SHIFT);
        end

        if (cmd.set_status)
        begin
            stat_reg <= cmd.status_code;
        end

        if (cmd.load_out)
        begin
            out_page_reg <= page_reg;
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= cnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign page_address = out_page_reg;
    assign status       = out_stat_reg;
    assign free_count   = out_cnt_reg;

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_write |-> (w_reg < WIU_W'(BITMAP_WORDS)) && (n_reg != '0))
        else $error("bitmap walk beyond the managed words");

    a_take_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_take |-> !(&rd_reg) && $onehot(onehot))
        else $error("page taken from a full word");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result register overwritten while held");

    a_addr_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_take |=> cmd.make_addr)
        else $error("allocated page index without address");

endmodule

`default_nettype wire

FILE: rtl/page_bitmap_allocator_unit.sv
// Top level of the bitmap page frame allocator.
// The block hands out, frees and reserves physical pages over a used-page bitmap held
// in a single-port memory of BITMAP_WORDS words of WORD_BITS bits, one bit per page at
// memory_base + index * 2^PAGE_SHIFT. After reset the block clears the bitmap, one word
// per cycle, and holds in_stall high meanwhile; configuration writes are taken at any
// time. Writing managed_pages loads the free count but leaves the bitmap as it is. One
// request is worked on at a time, and each request gives exactly one result. An
// allocation scans the bitmap words up to the first one with a clear bit, reading one
// word per cycle from the memory port. A free goes through setup, a word-index division
// by multiplication, and one read-modify-write of the memory. A mark-unusable request
// reads each touched word, merges it with a bit mask and writes it back through the
// same port; requests that are rejected at dispatch or touch nothing skip the memory.
// The result sits in an output register, so the next request is accepted while a
// result still waits to be taken.
`default_nettype none

module page_bitmap_allocator_unit #(
    parameter int BITMAP_WORDS = pba_pkg::BITMAP_WORDS_DEF,
    parameter int PAGE_SHIFT   = pba_pkg::PAGE_SHIFT_DEF,
    parameter int WORD_BITS    = pba_pkg::WORD_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [pba_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [pba_pkg::ADDR_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     action,
    input  wire logic [pba_pkg::ADDR_W-1:0]     address,
    input  wire logic [pba_pkg::ADDR_W-1:0]     length,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [pba_pkg::ADDR_W-1:0]          page_address,
    output logic [1:0]                          status,
    output logic [pba_pkg::COUNT_W-1:0]         free_count
);
    import pba_pkg::*;

    // Commands flow from the controller to the datapath, status flags flow back.
    cmd_t cmd;
    sts_t sts;

    pba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath owns the bitmap memory, the configuration registers, the free count
    // and the result register that faces the output channel.
    pba_datapath #(
        .BITMAP_WORDS (BITMAP_WORDS),
        .PAGE_SHIFT   (PAGE_SHIFT),
        .WORD_BITS    (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .address      (address),
        .length       (length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .page_address (page_address),
        .status       (status),
        .free_count   (free_count)
    );

endmodule

`default_nettype wire
